// File: rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// Primitive assembly package
// Shared widths, topology codes and the records passed between the front end,
// the command queue and the triangle back end.
// ----------------------------------------------------------------------------
package pat_pkg;

    // Vertex number, stride and offset widths
    localparam int VIDX_W   = 16;
    localparam int STRIDE_W = 4;
    localparam int PROD_W   = VIDX_W + STRIDE_W;
    localparam int OFFSET_W = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXCOORDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLORS    = 3'd3;

    // Topology codes
    localparam logic [2:0] TOPO_TRIANGLES  = 3'd0;
    localparam logic [2:0] TOPO_STRIP      = 3'd1;
    localparam logic [2:0] TOPO_FAN        = 3'd2;
    localparam logic [2:0] TOPO_QUADS      = 3'd3;
    localparam logic [2:0] TOPO_QUAD_STRIP = 3'd4;

    // Per-attribute stride contributions in floats
    localparam logic [STRIDE_W-1:0] STRIDE_POS      = 4'd3;
    localparam logic [STRIDE_W-1:0] STRIDE_NORMALS  = 4'd3;
    localparam logic [STRIDE_W-1:0] STRIDE_TEXCOORD = 4'd2;
    localparam logic [STRIDE_W-1:0] STRIDE_COLORS   = 4'd4;

    // Command queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0] topology;
        logic       has_normals;
        logic       has_texcoords;
        logic       has_colors;
    } t_cfg;

    // One primitive: first triangle (a,b,c), optional second triangle (c,b,d)
    typedef struct packed {
        logic [VIDX_W-1:0]   a;
        logic [VIDX_W-1:0]   b;
        logic [VIDX_W-1:0]   c;
        logic [VIDX_W-1:0]   d;
        logic                two;
        logic [STRIDE_W-1:0] stride;
    } t_cmd;

endpackage

// File: rtl/pat_vtx_if.sv
// ----------------------------------------------------------------------------
// Vertex arrival channel
// Valid/ready channel carrying one vertex arrival per transaction.
// ----------------------------------------------------------------------------
interface pat_vtx_if;
    logic valid;
    logic ready;
    logic end_of_buffer;

    modport source (output valid, output end_of_buffer, input ready);
    modport sink   (input valid, input end_of_buffer, output ready);
endinterface

// File: rtl/pat_tri_if.sv
// ----------------------------------------------------------------------------
// Triangle result channel
// Valid/ready channel carrying one triangle's three corner offsets.
// ----------------------------------------------------------------------------
interface pat_tri_if;
    import pat_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] first_offset;
    logic [OFFSET_W-1:0] second_offset;
    logic [OFFSET_W-1:0] third_offset;
    logic                last_of_run;

    modport source (output valid, output first_offset, output second_offset,
                    output third_offset, output last_of_run, input ready);
    modport sink   (input valid, input first_offset, input second_offset,
                    input third_offset, input last_of_run, output ready);
endinterface

// File: rtl/pat_front.sv
// ----------------------------------------------------------------------------
// Primitive assembly front end
// Counts vertices in the current buffer and turns each vertex that completes
// a primitive into a command for the back end.
// ----------------------------------------------------------------------------
module pat_front
    import pat_pkg::*;
#(
    parameter int MAX_VERTICES = 65536
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_accept,
    input  logic i_end_of_buffer,
    output logic o_push,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [1:0]        r_phase;
    logic [1:0]        n_phase;
    logic              w_room;
    logic [VIDX_W-1:0] w_k;
    logic              w_hit;

    assign w_room = (r_count < CNT_W'(MAX_VERTICES));
    assign w_k    = VIDX_W'(r_count);

    // Build the stride and classify the arriving vertex against the topology
    always_comb begin
        o_cmd.stride = STRIDE_POS;
        if (i_cfg.has_normals) begin
            o_cmd.stride = o_cmd.stride + STRIDE_NORMALS;
        end
        if (i_cfg.has_texcoords) begin
            o_cmd.stride = o_cmd.stride + STRIDE_TEXCOORD;
        end
        if (i_cfg.has_colors) begin
            o_cmd.stride = o_cmd.stride + STRIDE_COLORS;
        end

        w_hit     = 1'b0;
        o_cmd.two = 1'b0;
        o_cmd.a   = w_k - VIDX_W'(2);
        o_cmd.b   = w_k - VIDX_W'(1);
        o_cmd.c   = w_k;
        o_cmd.d   = w_k;
        case (i_cfg.topology)
            TOPO_TRIANGLES: begin
                // Third vertex of each group of three
                w_hit = (r_phase == 2'd2);
            end
            TOPO_STRIP: begin
                w_hit = (w_k >= VIDX_W'(2));
                // Odd strip triangles swap their first two corners
                if (w_k[0]) begin
                    o_cmd.a = w_k - VIDX_W'(1);
                    o_cmd.b = w_k - VIDX_W'(2);
                end
            end
            TOPO_FAN: begin
                w_hit   = (w_k >= VIDX_W'(2));
                o_cmd.a = '0;
            end
            TOPO_QUADS, TOPO_QUAD_STRIP: begin
                if (i_cfg.topology == TOPO_QUADS) begin
                    w_hit = (w_k[1:0] == 2'b11);
                end else begin
                    w_hit = (w_k >= VIDX_W'(3)) && w_k[0];
                end
                o_cmd.two = 1'b1;
                o_cmd.a   = w_k - VIDX_W'(3);
                o_cmd.b   = w_k - VIDX_W'(2);
                o_cmd.c   = w_k - VIDX_W'(1);
                o_cmd.d   = w_k;
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    assign o_push = i_accept && w_room && w_hit;

    // Advance the counter and its position in a group of three, saturate
    // when full, restart on end of buffer
    always_comb begin
        n_count = r_count;
        n_phase = r_phase;
        if (i_accept) begin
            if (i_end_of_buffer) begin
                n_count = '0;
                n_phase = '0;
            end else if (w_room) begin
                n_count = r_count + CNT_W'(1);
                n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= '0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

endmodule

// File: rtl/pat_fifo.sv
// ----------------------------------------------------------------------------
// Primitive command queue
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pat_fifo
    import pat_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_cmd   = r_mem[r_rptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/pat_back.sv
// ----------------------------------------------------------------------------
// Triangle back end
// Expands each queued primitive into one or two triangles, scales the corner
// vertex numbers by the stride and holds the result in an output register.
// ----------------------------------------------------------------------------
module pat_back
    import pat_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    output logic       o_pop,
    pat_tri_if.source  o_tri
);

    logic                r_valid;
    logic                r_second;
    logic [OFFSET_W-1:0] r_first_offset;
    logic [OFFSET_W-1:0] r_second_offset;
    logic [OFFSET_W-1:0] r_third_offset;
    logic                r_last;

    logic                w_load;
    logic                w_take;
    logic [VIDX_W-1:0]   w_c0;
    logic [VIDX_W-1:0]   w_c2;
    logic                w_last;
    logic [PROD_W-1:0]   w_p0;
    logic [PROD_W-1:0]   w_p1;
    logic [PROD_W-1:0]   w_p2;

    assign w_load = !r_valid || o_tri.ready;
    assign w_take = w_load && !i_empty;

    // Select the corners: (a,b,c) first, then (c,b,d) for a pair
    assign w_c0   = r_second ? i_cmd.c : i_cmd.a;
    assign w_c2   = r_second ? i_cmd.d : i_cmd.c;
    assign w_last = r_second || !i_cmd.two;
    assign o_pop  = w_take && w_last;

    assign w_p0 = PROD_W'(w_c0) * PROD_W'(i_cmd.stride);
    assign w_p1 = PROD_W'(i_cmd.b) * PROD_W'(i_cmd.stride);
    assign w_p2 = PROD_W'(w_c2) * PROD_W'(i_cmd.stride);

    // Load the output register when empty or drained
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_first_offset  <= OFFSET_W'(w_p0);
            r_second_offset <= OFFSET_W'(w_p1);
            r_third_offset  <= OFFSET_W'(w_p2);
            r_last          <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= !i_empty;
            end
            if (w_take) begin
                r_second <= i_cmd.two && !r_second;
            end
        end
    end

    assign o_tri.valid         = r_valid;
    assign o_tri.first_offset  = r_first_offset;
    assign o_tri.second_offset = r_second_offset;
    assign o_tri.third_offset  = r_third_offset;
    assign o_tri.last_of_run   = r_last;

endmodule

// File: rtl/primitive_assembly_to_triangles.sv
// ----------------------------------------------------------------------------
// Primitive assembly to triangles
// Counts vertex arrivals and emits triangles as float offsets of corners.
// ----------------------------------------------------------------------------
// Usage:
//   i_vtx carries one vertex arrival per transaction; end_of_buffer marks the
//   last vertex of a buffer and restarts the vertex count after it.
//   o_tri carries one triangle per transaction: three corner offsets (vertex
//   number times stride) and last_of_run on the final triangle of a vertex.
//   Configuration (topology, attribute flags) is written through i_cfg_we,
//   i_cfg_idx and i_cfg_data while the block is idle; writes apply at once.
// Timing:
//   A vertex is taken every cycle while the four-entry command queue has
//   room. A completing vertex is written into the command queue, and its
//   first triangle is then loaded from the queue into the output register
//   that drives o_tri. While o_tri is ready and the queue is not empty, the
//   back end issues one triangle per cycle; a quad or quad-strip pair gives two.
// Reset and stall:
//   Reset clears the configuration, the vertex count, the queue and the
//   output valid flag. While o_tri is stalled the output register holds, and
//   vertices keep being accepted until the queue fills.
// ----------------------------------------------------------------------------
module primitive_assembly_to_triangles
    import pat_pkg::*;
#(
    parameter int MAX_VERTICES = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pat_vtx_if.sink               i_vtx,
    pat_tri_if.source             o_tri,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    logic w_accept;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOPOLOGY:  r_cfg.topology      <= i_cfg_data;
                CFG_NORMALS:   r_cfg.has_normals   <= i_cfg_data[0];
                CFG_TEXCOORDS: r_cfg.has_texcoords <= i_cfg_data[0];
                CFG_COLORS:    r_cfg.has_colors    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign i_vtx.ready = !w_full;
    assign w_accept    = i_vtx.valid && !w_full;

    pat_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_accept        (w_accept),
        .i_end_of_buffer (i_vtx.end_of_buffer),
        .o_push          (w_push),
        .o_cmd           (w_push_cmd)
    );

    pat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    pat_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_tri   (o_tri)
    );

endmodule
